// File: rtl/v2d_pkg.sv
// ----------------------------------------------------------------------------
// v2d_pkg
// Shared types, stage schedule and constants of the 2D vector arithmetic unit.
// ----------------------------------------------------------------------------
package v2d_pkg;

	// command codes
	typedef enum logic [2:0] {
		CMD_ADD       = 3'd0,
		CMD_SUB       = 3'd1,
		CMD_SCALE     = 3'd2,
		CMD_DOT       = 3'd3,
		CMD_LENGTH    = 3'd4,
		CMD_NORMALIZE = 3'd5,
		CMD_ROTATE    = 3'd6
	} cmd_t;

	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int GUARD_BITS    = 16;
	localparam int ANG_FRAC      = 30;
	localparam int GAIN_SHIFT    = ANG_FRAC - GUARD_BITS;

	// widths
	localparam int WIDE_W = 66 - FRAC_BITS;           // unsaturated results
	localparam int CX_W   = 52;                       // cordic x/y with guard bits
	localparam int Z_W    = 35;                       // cordic angle
	localparam int ZM_W   = 32 + ANG_FRAC - FRAC_BITS; // |angle| before reduction
	localparam int QW     = FRAC_BITS + 1;            // normalize quotient
	localparam int NR_W   = 32 + FRAC_BITS + 1;       // normalize remainder
	localparam int SQ_W   = 64;

	// angle constants, unsigned Q3.30; gain, Q2.30
	localparam logic [32:0] ANG_TWO_PI  = 33'd6746518852;
	localparam logic [32:0] ANG_PI      = 33'd3373259426;
	localparam logic [32:0] ANG_HALF_PI = 33'd1686629713;
	localparam logic [32:0] ANG_3HALF   = 33'd5059889139;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	// stage schedule
	localparam int ST_MUL      = 1;
	localparam int ST_INIT     = 2;
	localparam int SQ_FIRST    = 3;
	localparam int SQ_STEPS    = 32;
	localparam int ST_SQ_RND   = SQ_FIRST + SQ_STEPS;
	localparam int ST_NSET     = ST_SQ_RND + 1;
	localparam int DIV_FIRST   = ST_NSET + 1;
	localparam int DIV_STEPS   = QW;
	localparam int ST_NFIN     = DIV_FIRST + DIV_STEPS;
	localparam int ST_SAT      = ST_NFIN + 1;
	localparam int DEPTH       = ST_SAT + 1;
	localparam int MOD_FIRST   = 3;
	localparam int MOD_STEPS   = ZM_W - 33;
	localparam int ST_MRED     = MOD_FIRST + MOD_STEPS;
	localparam int ST_FOLD     = ST_MRED + 1;
	localparam int CR_FIRST    = ST_FOLD + 1;
	localparam int ST_CRND     = CR_FIRST + CORDIC_STAGES;

	typedef struct packed {
		logic [2:0]               cmd;
		logic signed [31:0]       ax;
		logic signed [31:0]       ay;
		logic signed [31:0]       bx;
		logic signed [31:0]       by;
		logic signed [31:0]       k;
		logic signed [63:0]       p_xk;
		logic signed [63:0]       p_yk;
		logic signed [63:0]       p_xb;
		logic signed [63:0]       p_yb;
		logic signed [63:0]       p_xx;
		logic signed [63:0]       p_yy;
		logic signed [63:0]       p_xg;
		logic signed [63:0]       p_yg;
		logic signed [WIDE_W-1:0] rx;
		logic signed [WIDE_W-1:0] ry;
		logic signed [WIDE_W-1:0] rs;
		logic [SQ_W-1:0]          sq_rem;
		logic [SQ_W-1:0]          sq_res;
		logic [ZM_W-1:0]          zm;
		logic                     zneg;
		logic signed [Z_W-1:0]    z;
		logic signed [CX_W-1:0]   cx;
		logic signed [CX_W-1:0]   cy;
		logic [31:0]              len;
		logic                     nzero;
		logic [NR_W-1:0]          nr_x;
		logic [NR_W-1:0]          nr_y;
		logic [QW-1:0]            nq_x;
		logic [QW-1:0]            nq_y;
		logic signed [31:0]       o_x;
		logic signed [31:0]       o_y;
		logic signed [31:0]       o_s;
		logic                     ovf;
	} pipe_t;

	// arctangent of 2^-i, Q0.30, truncated
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:    r = 30'd843314856;
			5'd1:    r = 30'd497837829;
			5'd2:    r = 30'd263043836;
			5'd3:    r = 30'd133525158;
			5'd4:    r = 30'd67021686;
			5'd5:    r = 30'd33543515;
			5'd6:    r = 30'd16775850;
			5'd7:    r = 30'd8388437;
			5'd8:    r = 30'd4194282;
			5'd9:    r = 30'd2097149;
			5'd10:   r = 30'd1048575;
			5'd11:   r = 30'd524287;
			5'd12:   r = 30'd262143;
			5'd13:   r = 30'd131071;
			5'd14:   r = 30'd65535;
			5'd15:   r = 30'd32767;
			5'd16:   r = 30'd16383;
			5'd17:   r = 30'd8191;
			5'd18:   r = 30'd4095;
			5'd19:   r = 30'd2047;
			5'd20:   r = 30'd1023;
			5'd21:   r = 30'd511;
			5'd22:   r = 30'd255;
			5'd23:   r = 30'd127;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic sat_hit(input logic signed [WIDE_W-1:0] v);
		return !((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] r;
		if (sat_hit(v)) begin
			r = v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/vector2d_arith_unit.sv
// ----------------------------------------------------------------------------
// vector2d_arith_unit
// Pipelined Q16.16 2D vector unit: add, subtract, scale, dot, length,
// normalize and CORDIC rotate, with 32-bit saturation.
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_stall, command, a_x..b_y, scalar   | in word
//  output  | out_valid, out_stall, result_x/y/scalar, overflow | out word
//  config  | cfg_valid, cfg_ready, cfg_data (zero threshold) | register write
//
//  a word enters every cycle unless the pipe is frozen by a stalled result
//  the depth is set by the normalize path: 32 square-root stages followed by a
//  17-stage restoring divider, all other commands ride along
//  one stall moves the whole pipe: it freezes while the last stage holds a
//  word that is stalled, and then the input stalls too
//  reset clears the valid bits and loads the threshold with 1
//
module vector2d_arith_unit (
	input  logic               clk,
	input  logic               arst_n,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] scalar_operand,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_x,
	output logic signed [31:0] result_y,
	output logic signed [31:0] result_scalar,
	output logic               overflow,
	// threshold register
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	v2d_pkg::pipe_t pipe_s [v2d_pkg::DEPTH];
	v2d_pkg::pipe_t nxt    [v2d_pkg::DEPTH];
	logic           vld_s  [v2d_pkg::DEPTH];
	logic [15:0]    thr_q;
	logic           adv;

	// whole pipe advances unless the finished word is held
	assign adv       = !(vld_s[v2d_pkg::DEPTH-1] && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd1;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// input capture, stage 0
	always_comb begin
		nxt[0]     = pipe_s[0];
		nxt[0].cmd = command;
		nxt[0].ax  = a_x;
		nxt[0].ay  = a_y;
		nxt[0].bx  = b_x;
		nxt[0].by  = b_y;
		nxt[0].k   = scalar_operand;
	end

	for (genvar s = 1; s < v2d_pkg::DEPTH; s++) begin : g_stage
		// per-stage step indexes, clamped outside their window
		localparam int SQ_J = (s >= v2d_pkg::SQ_FIRST && s < v2d_pkg::ST_SQ_RND)
			? s - v2d_pkg::SQ_FIRST : 0;
		localparam int MOD_J = (s >= v2d_pkg::MOD_FIRST && s < v2d_pkg::ST_MRED)
			? v2d_pkg::MOD_STEPS - 1 - (s - v2d_pkg::MOD_FIRST) : 0;
		localparam int CR_I = (s >= v2d_pkg::CR_FIRST && s < v2d_pkg::ST_CRND)
			? s - v2d_pkg::CR_FIRST : 0;
		localparam int DIV_B = (s >= v2d_pkg::DIV_FIRST && s < v2d_pkg::ST_NFIN)
			? v2d_pkg::DIV_STEPS - 1 - (s - v2d_pkg::DIV_FIRST) : 0;

		always_comb begin : p_step
			v2d_pkg::pipe_t                   n;
			logic signed [64:0]               dot_sum;
			logic [31:0]                      kmag;
			logic [31:0]                      mag_x;
			logic [31:0]                      mag_y;
			logic [v2d_pkg::SQ_W-1:0]         sq_bit;
			logic [v2d_pkg::SQ_W-1:0]         sq_try;
			logic [v2d_pkg::ZM_W-1:0]         mod_sub;
			logic signed [v2d_pkg::CX_W-1:0]  sh_x;
			logic signed [v2d_pkg::CX_W-1:0]  sh_y;
			logic signed [v2d_pkg::Z_W-1:0]   at;
			logic [v2d_pkg::NR_W-1:0]         dvs;
			logic signed [v2d_pkg::WIDE_W-1:0] qx;
			logic signed [v2d_pkg::WIDE_W-1:0] qy;

			n       = pipe_s[s-1];
			dot_sum = {n.p_xb[63], n.p_xb} + {n.p_yb[63], n.p_yb};
			kmag    = n.k[31] ? 32'(-n.k) : 32'(n.k);
			mag_x   = n.ax[31] ? 32'(-n.ax) : 32'(n.ax);
			mag_y   = n.ay[31] ? 32'(-n.ay) : 32'(n.ay);
			sq_bit  = v2d_pkg::SQ_W'(1) << (62 - 2 * SQ_J);
			sq_try  = n.sq_res + sq_bit;
			mod_sub = v2d_pkg::ZM_W'(v2d_pkg::ANG_TWO_PI) << MOD_J;
			sh_x    = n.cx >>> CR_I;
			sh_y    = n.cy >>> CR_I;
			at      = $signed(v2d_pkg::Z_W'(v2d_pkg::atan_q30(5'(CR_I))));
			dvs     = v2d_pkg::NR_W'(n.len) << DIV_B;
			qx      = $signed(v2d_pkg::WIDE_W'(n.nq_x));
			qy      = $signed(v2d_pkg::WIDE_W'(n.nq_y));

			if (s == v2d_pkg::ST_MUL) begin
				n.p_xk = n.ax * n.k;
				n.p_yk = n.ay * n.k;
				n.p_xb = n.ax * n.bx;
				n.p_yb = n.ay * n.by;
				n.p_xx = n.ax * n.ax;
				n.p_yy = n.ay * n.ay;
				n.p_xg = n.ax * v2d_pkg::GAIN_Q30;
				n.p_yg = n.ay * v2d_pkg::GAIN_Q30;
			end

			if (s == v2d_pkg::ST_INIT) begin
				n.rx = '0;
				n.ry = '0;
				n.rs = '0;
				case (n.cmd)
					v2d_pkg::CMD_ADD: begin
						n.rx = v2d_pkg::WIDE_W'(n.ax) + v2d_pkg::WIDE_W'(n.bx);
						n.ry = v2d_pkg::WIDE_W'(n.ay) + v2d_pkg::WIDE_W'(n.by);
					end
					v2d_pkg::CMD_SUB: begin
						n.rx = v2d_pkg::WIDE_W'(n.ax) - v2d_pkg::WIDE_W'(n.bx);
						n.ry = v2d_pkg::WIDE_W'(n.ay) - v2d_pkg::WIDE_W'(n.by);
					end
					v2d_pkg::CMD_SCALE: begin
						// round half up on the dropped fraction
						n.rx = {{(v2d_pkg::WIDE_W-64+v2d_pkg::FRAC_BITS){n.p_xk[63]}},
							n.p_xk[63:v2d_pkg::FRAC_BITS]}
							+ {{(v2d_pkg::WIDE_W-1){1'b0}}, n.p_xk[v2d_pkg::FRAC_BITS-1]};
						n.ry = {{(v2d_pkg::WIDE_W-64+v2d_pkg::FRAC_BITS){n.p_yk[63]}},
							n.p_yk[63:v2d_pkg::FRAC_BITS]}
							+ {{(v2d_pkg::WIDE_W-1){1'b0}}, n.p_yk[v2d_pkg::FRAC_BITS-1]};
					end
					v2d_pkg::CMD_DOT: begin
						n.rs = {{(v2d_pkg::WIDE_W-65+v2d_pkg::FRAC_BITS){dot_sum[64]}},
							dot_sum[64:v2d_pkg::FRAC_BITS]}
							+ {{(v2d_pkg::WIDE_W-1){1'b0}}, dot_sum[v2d_pkg::FRAC_BITS-1]};
					end
					default: ;
				endcase
				n.sq_rem = n.p_xx + n.p_yy;
				n.sq_res = '0;
				n.cx = {{(v2d_pkg::CX_W-64+v2d_pkg::GAIN_SHIFT){n.p_xg[63]}},
					n.p_xg[63:v2d_pkg::GAIN_SHIFT]}
					+ {{(v2d_pkg::CX_W-1){1'b0}}, n.p_xg[v2d_pkg::GAIN_SHIFT-1]};
				n.cy = {{(v2d_pkg::CX_W-64+v2d_pkg::GAIN_SHIFT){n.p_yg[63]}},
					n.p_yg[63:v2d_pkg::GAIN_SHIFT]}
					+ {{(v2d_pkg::CX_W-1){1'b0}}, n.p_yg[v2d_pkg::GAIN_SHIFT-1]};
				n.zm   = v2d_pkg::ZM_W'(kmag) << (v2d_pkg::ANG_FRAC - v2d_pkg::FRAC_BITS);
				n.zneg = n.k[31];
			end

			// square root, one result bit per stage
			if (s >= v2d_pkg::SQ_FIRST && s < v2d_pkg::ST_SQ_RND) begin
				if (n.sq_rem >= sq_try) begin
					n.sq_rem = n.sq_rem - sq_try;
					n.sq_res = (n.sq_res >> 1) + sq_bit;
				end else begin
					n.sq_res = n.sq_res >> 1;
				end
			end

			// angle magnitude modulo 2pi, one quotient bit per stage
			if (s >= v2d_pkg::MOD_FIRST && s < v2d_pkg::ST_MRED) begin
				if (n.zm >= mod_sub) begin
					n.zm = n.zm - mod_sub;
				end
			end

			// back to a signed remainder, then into [0, 2pi)
			if (s == v2d_pkg::ST_MRED) begin
				if (n.zneg && n.zm != '0) begin
					n.z = $signed(v2d_pkg::Z_W'(v2d_pkg::ANG_TWO_PI) - v2d_pkg::Z_W'(n.zm));
				end else begin
					n.z = $signed(v2d_pkg::Z_W'(n.zm));
				end
			end

			// into [-pi/2, pi/2], turning the vector by pi where needed
			if (s == v2d_pkg::ST_FOLD) begin
				if (n.z <= $signed(v2d_pkg::Z_W'(v2d_pkg::ANG_HALF_PI))) begin
					n.z = n.z;
				end else if (n.z < $signed(v2d_pkg::Z_W'(v2d_pkg::ANG_3HALF))) begin
					n.z  = n.z - $signed(v2d_pkg::Z_W'(v2d_pkg::ANG_PI));
					n.cx = -n.cx;
					n.cy = -n.cy;
				end else begin
					n.z = n.z - $signed(v2d_pkg::Z_W'(v2d_pkg::ANG_TWO_PI));
				end
			end

			// cordic micro-rotation
			if (s >= v2d_pkg::CR_FIRST && s < v2d_pkg::ST_CRND) begin
				if (n.z >= 0) begin
					n.cx = n.cx - sh_y;
					n.cy = n.cy + sh_x;
					n.z  = n.z - at;
				end else begin
					n.cx = n.cx + sh_y;
					n.cy = n.cy - sh_x;
					n.z  = n.z + at;
				end
			end

			if (s == v2d_pkg::ST_CRND && n.cmd == v2d_pkg::CMD_ROTATE) begin
				n.rx = {{(v2d_pkg::WIDE_W-v2d_pkg::CX_W+v2d_pkg::GUARD_BITS){n.cx[v2d_pkg::CX_W-1]}},
					n.cx[v2d_pkg::CX_W-1:v2d_pkg::GUARD_BITS]}
					+ {{(v2d_pkg::WIDE_W-1){1'b0}}, n.cx[v2d_pkg::GUARD_BITS-1]};
				n.ry = {{(v2d_pkg::WIDE_W-v2d_pkg::CX_W+v2d_pkg::GUARD_BITS){n.cy[v2d_pkg::CX_W-1]}},
					n.cy[v2d_pkg::CX_W-1:v2d_pkg::GUARD_BITS]}
					+ {{(v2d_pkg::WIDE_W-1){1'b0}}, n.cy[v2d_pkg::GUARD_BITS-1]};
			end

			// round the root to nearest
			if (s == v2d_pkg::ST_SQ_RND) begin
				n.len = (n.sq_rem > n.sq_res) ? 32'(n.sq_res + 1'b1) : n.sq_res[31:0];
				if (n.cmd == v2d_pkg::CMD_LENGTH) begin
					n.rs = $signed(v2d_pkg::WIDE_W'(n.len));
				end
			end

			// normalize setup: magnitudes scaled up, half the divisor added
			if (s == v2d_pkg::ST_NSET) begin
				n.nzero = (n.len == '0) || (n.len < 32'(thr_q));
				n.nr_x  = v2d_pkg::NR_W'({mag_x, {v2d_pkg::FRAC_BITS{1'b0}}})
					+ v2d_pkg::NR_W'(n.len >> 1);
				n.nr_y  = v2d_pkg::NR_W'({mag_y, {v2d_pkg::FRAC_BITS{1'b0}}})
					+ v2d_pkg::NR_W'(n.len >> 1);
				n.nq_x  = '0;
				n.nq_y  = '0;
			end

			// restoring divide, one quotient bit per stage
			if (s >= v2d_pkg::DIV_FIRST && s < v2d_pkg::ST_NFIN) begin
				if (n.nr_x >= dvs) begin
					n.nr_x        = n.nr_x - dvs;
					n.nq_x[DIV_B] = 1'b1;
				end
				if (n.nr_y >= dvs) begin
					n.nr_y        = n.nr_y - dvs;
					n.nq_y[DIV_B] = 1'b1;
				end
			end

			if (s == v2d_pkg::ST_NFIN && n.cmd == v2d_pkg::CMD_NORMALIZE) begin
				if (n.nzero) begin
					n.rx = '0;
					n.ry = '0;
				end else begin
					n.rx = n.ax[31] ? -qx : qx;
					n.ry = n.ay[31] ? -qy : qy;
				end
			end

			if (s == v2d_pkg::ST_SAT) begin
				n.o_x = v2d_pkg::sat32(n.rx);
				n.o_y = v2d_pkg::sat32(n.ry);
				n.o_s = v2d_pkg::sat32(n.rs);
				n.ovf = v2d_pkg::sat_hit(n.rx) || v2d_pkg::sat_hit(n.ry)
					|| v2d_pkg::sat_hit(n.rs);
			end

			nxt[s] = n;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 0; s < v2d_pkg::DEPTH; s++) begin
				pipe_s[s] <= nxt[s];
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < v2d_pkg::DEPTH; s++) begin
				vld_s[s] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int s = 1; s < v2d_pkg::DEPTH; s++) begin
				vld_s[s] <= vld_s[s-1];
			end
		end
	end

	assign out_valid     = vld_s[v2d_pkg::DEPTH-1];
	assign result_x      = pipe_s[v2d_pkg::DEPTH-1].o_x;
	assign result_y      = pipe_s[v2d_pkg::DEPTH-1].o_y;
	assign result_scalar = pipe_s[v2d_pkg::DEPTH-1].o_s;
	assign overflow      = pipe_s[v2d_pkg::DEPTH-1].ovf;

endmodule

// File: rtl/v2d_checker.sv
// ----------------------------------------------------------------------------
// v2d_checker
// Port-level checks of the 2D vector arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module v2d_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] result_x,
	input logic signed [31:0] result_y,
	input logic signed [31:0] result_scalar,
	input logic               overflow
);

	// a held result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_x) && $stable(result_y)
			&& $stable(result_scalar) && $stable(overflow))
		else $error("result word changed while stalled");

	// input backs up only behind a held result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (in_stall == (out_valid && out_stall)))
		else $error("input stall does not follow output stall");

	// overflow means some field sits at a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			result_x == 32'sh7FFF_FFFF || result_x == 32'sh8000_0000
			|| result_y == 32'sh7FFF_FFFF || result_y == 32'sh8000_0000
			|| result_scalar == 32'sh7FFF_FFFF || result_scalar == 32'sh8000_0000)
		else $error("overflow without a saturated field");

endmodule

bind vector2d_arith_unit v2d_checker u_v2d_checker (.*);
